// ===== hw/rtl/mhp_pkg.sv =====
// Shared constants and control types for the multiplicative hash partitioner.
package mhp_pkg;

  localparam int VALUE_W     = 32;
  localparam int HB_W        = 4;
  localparam int MAX_HB      = 8;
  localparam int PART_W      = 8;
  localparam int SLOT_W      = 20;
  localparam int CNT_W       = 21;
  localparam int NUM_PARTS   = 1 << PART_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 21;
  localparam int OUT_TDATA_W = 72;

  localparam logic [VALUE_W-1:0] GOLDEN_Q32 = 32'h9E3779B9;
  localparam logic [CNT_W-1:0]   CAP_MAX    = CNT_W'(1 << SLOT_W);
  localparam logic [CNT_W-1:0]   CAP_RESET  = CNT_W'(1048576);
  localparam logic [HB_W-1:0]    HB_RESET   = HB_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_PART_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic rd;
    logic upd;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/mhp_ctrl.sv =====
// Sequencer for one word at a time: accept, multiply, counter read, update.
module mhp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mhp_pkg::sts_t sts,
  output mhp_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_READ,
    S_UPD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_READ;
      S_READ: state_nxt = S_UPD;
      S_UPD:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready   = (state_r == S_IDLE);
  assign cmd.load_in = in_tready && in_tvalid;
  assign cmd.mul     = (state_r == S_MUL);
  assign cmd.rd      = (state_r == S_READ);
  assign cmd.upd     = (state_r == S_UPD) && sts.out_free;

endmodule

// ===== hw/rtl/mhp_datapath.sv =====
// Hash multiplier, fill counter memory, config registers and output register.
module mhp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mhp_pkg::cmd_t                       cmd,
  output mhp_pkg::sts_t                       sts,
  input  logic                                cfg_we,
  input  logic [mhp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mhp_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [mhp_pkg::VALUE_W-1:0]         in_tdata,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [mhp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);

  logic [mhp_pkg::HB_W-1:0]    hb_r;
  logic [mhp_pkg::CNT_W-1:0]   cap_r;
  logic [mhp_pkg::HB_W-1:0]    hb_eff;
  logic [mhp_pkg::CNT_W-1:0]   cap_eff;

  logic [mhp_pkg::VALUE_W-1:0] value_r;
  logic [31:0]                 frac_r;
  logic [mhp_pkg::PART_W-1:0]  part;
  logic [mhp_pkg::PART_W-1:0]  part_r;
  logic [mhp_pkg::CNT_W-1:0]   rd_r;
  logic                        rd_vld_r;
  logic [mhp_pkg::CNT_W-1:0]   fill;
  logic                        ovf;
  logic [mhp_pkg::PART_W-1:0]  key;

  logic [mhp_pkg::CNT_W-1:0]   fill_mem [mhp_pkg::NUM_PARTS];
  logic [mhp_pkg::NUM_PARTS-1:0] vld_r;

  logic                        out_valid_r;
  logic [mhp_pkg::PART_W-1:0]  o_part_r;
  logic [mhp_pkg::SLOT_W-1:0]  o_slot_r;
  logic [mhp_pkg::PART_W-1:0]  o_key_r;
  logic [mhp_pkg::VALUE_W-1:0] o_payload_r;
  logic                        o_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r  <= mhp_pkg::HB_RESET;
      cap_r <= mhp_pkg::CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mhp_pkg::CFG_PART_BITS) hb_r <= cfg_wdata[mhp_pkg::HB_W-1:0];
      if (cfg_index == mhp_pkg::CFG_CAPACITY)  cap_r <= cfg_wdata;
    end
  end

  assign hb_eff  = (hb_r > mhp_pkg::HB_W'(mhp_pkg::MAX_HB)) ?
                   mhp_pkg::HB_W'(mhp_pkg::MAX_HB) : hb_r;
  assign cap_eff = (cap_r > mhp_pkg::CAP_MAX) ? mhp_pkg::CAP_MAX : cap_r;

  // top hb_eff bits of the Q0.32 fraction; zero hash bits shifts everything out
  assign part = mhp_pkg::PART_W'(frac_r[31 -: mhp_pkg::PART_W] >>
                (mhp_pkg::HB_W'(mhp_pkg::MAX_HB) - hb_eff));
  assign key  = value_r[mhp_pkg::PART_W-1:0] & ~(mhp_pkg::PART_W'('1) << hb_eff);

  always_ff @(posedge clk) begin
    if (cmd.load_in) value_r <= in_tdata;
    if (cmd.mul)     frac_r  <= 32'(value_r * mhp_pkg::GOLDEN_Q32);
    if (cmd.rd) begin
      part_r <= part;
      rd_r   <= fill_mem[part];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (cmd.rd) begin
      rd_vld_r <= vld_r[part];
    end
  end

  assign fill = rd_vld_r ? rd_r : '0;
  assign ovf  = (fill >= cap_eff);

  always_ff @(posedge clk) begin
    if (cmd.upd && !ovf) fill_mem[part_r] <= fill + mhp_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.upd && !ovf) begin
      vld_r[part_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      o_part_r    <= part_r;
      o_slot_r    <= ovf ? '0 : fill[mhp_pkg::SLOT_W-1:0];
      o_key_r     <= key;
      o_payload_r <= value_r;
      o_ovf_r     <= ovf;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {4'b0, o_payload_r, o_key_r, o_slot_r, o_part_r};
  assign out_tuser    = o_ovf_r;

endmodule

// ===== hw/rtl/multiplicative_hash_partitioner.sv =====
// Top level of the multiplicative hash partitioner.
//   channel | dir | tdata (low bit up)                     | tuser
//   in_     | in  | value[31:0]                            | -
//   out_    | out | part, slot, key, payload (68 + 4 pad)  | overflow
//   cfg_    | in  | 0 partition bit count, 1 part capacity | -
// A word is accepted in the idle state and reaches the output register after the
// multiply, counter memory read and counter update states, and the next word is
// taken only once the last has left the update state. The fill counter
// read-modify-write sets this. A new word is taken while the last result waits.
// Synchronous active-low reset clears all fill counters at once (valid bits).
// A stalled output holds the update stage until the output register frees.
module multiplicative_hash_partitioner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mhp_pkg::VALUE_W-1:0]         in_tdata,   // value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mhp_pkg::OUT_TDATA_W-1:0]     out_tdata,  // part, slot, key, payload
  output logic                                out_tuser,  // overflow
  input  logic                                cfg_we,
  input  logic [mhp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mhp_pkg::CFG_W-1:0]           cfg_wdata
);

  mhp_pkg::cmd_t cmd;
  mhp_pkg::sts_t sts;

  mhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mhp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while another is in flight");

  a_ovf_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[27:8] == 20'd0)
    else $error("overflow result carries a nonzero slot");

  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a word in flight");
`endif

endmodule
